[hdl/assf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// assf_pkg: shared types and constants for the snap smoothing filter
// Fixed-point widths, serial unit op codes, control structs, FSM states.
// ----------------------------------------------------------------------------
package assf_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int FRAC_BITS   = 16;
  localparam int ACC_BITS    = SAMPLE_BITS + FRAC_BITS;  // smooth value, Q12.16
  localparam int ERR_BITS    = 31;                       // error average, signed
  localparam int D_BITS      = 32;                       // sample minus smooth
  localparam int OPA_BITS    = 34;                       // serial unit operand A
  localparam int OPB_BITS    = FRAC_BITS + 1;            // serial unit operand B
  localparam int PROD_BITS   = OPA_BITS + OPB_BITS;
  localparam int MUL_STEPS   = OPB_BITS;
  localparam int DIV_STEPS   = FRAC_BITS;
  localparam int CNT_BITS    = $clog2(MUL_STEPS + 1);
  localparam int MULT_SHIFT  = 15;                       // Q1.15 multiplier
  localparam int MULT_BITS   = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [OPB_BITS-1:0]  ONE_FX     = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [OPB_BITS-1:0]  EMA_WEIGHT =
    OPB_BITS'((2 * (1 << FRAC_BITS) + 2) / 5);
  localparam logic [MULT_BITS-1:0] MULT_ONE   = MULT_BITS'(1 << MULT_SHIFT);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SLEEP_ENABLE       = 3'd0,
    CFG_EDGE_SNAP_ENABLE   = 3'd1,
    CFG_ACTIVITY_THRESHOLD = 3'd2,
    CFG_SNAP_MULTIPLIER    = 3'd3,
    CFG_FULL_SCALE         = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EMA_GO,
    S_EMA_WAIT,
    S_SLEEP,
    S_XMUL_GO,
    S_XMUL_WAIT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SMOOTH_GO,
    S_SMOOTH_WAIT,
    S_FINISH
  } state_t;

endpackage
`default_nettype wire

[hdl/assf_serial_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// assf_serial_unit: shared bit-serial multiply / divide
// MUL: signed A times unsigned B, one B bit per cycle, MSB first.
// DIV: restoring division, one quotient bit per cycle; remainder loads from A.
// ----------------------------------------------------------------------------
module assf_serial_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  assf_pkg::unit_ctrl_t                  ctrl,
  input  logic signed [assf_pkg::OPA_BITS-1:0]  operand_a,
  input  logic        [assf_pkg::OPB_BITS-1:0]  operand_b,
  output assf_pkg::unit_stat_t                  stat,
  output logic signed [assf_pkg::PROD_BITS-1:0] result
);

  logic                                   busy;
  logic                                   done;
  logic        [assf_pkg::CNT_BITS-1:0]   count;
  assf_pkg::unit_op_t                     op;
  logic signed [assf_pkg::OPA_BITS-1:0]   a_reg;
  logic        [assf_pkg::OPB_BITS-1:0]   b_reg;
  logic        [assf_pkg::OPB_BITS-1:0]   rem;
  logic signed [assf_pkg::PROD_BITS-1:0]  acc;

  logic signed [assf_pkg::PROD_BITS-1:0]  acc_next;
  logic        [assf_pkg::OPB_BITS-1:0]   b_next;
  logic        [assf_pkg::OPB_BITS-1:0]   rem_next;
  logic signed [assf_pkg::PROD_BITS-1:0]  mul_addend;
  logic        [assf_pkg::OPB_BITS:0]     rem_sh;
  logic        [assf_pkg::OPB_BITS:0]     rem_sub;
  logic                                   q_bit;

  always_comb begin
    mul_addend = b_reg[assf_pkg::OPB_BITS-1] ? assf_pkg::PROD_BITS'(a_reg) : '0;
    rem_sh     = {rem, 1'b0};
    rem_sub    = rem_sh - {1'b0, b_reg};
    q_bit      = (rem_sh >= {1'b0, b_reg});
    unique case (op)
      assf_pkg::OP_MUL: begin
        acc_next = (acc <<< 1) + mul_addend;
        b_next   = b_reg << 1;
        rem_next = rem;
      end
      assf_pkg::OP_DIV: begin
        acc_next = {acc[assf_pkg::PROD_BITS-2:0], q_bit};
        b_next   = b_reg;
        rem_next = q_bit ? rem_sub[assf_pkg::OPB_BITS-1:0] : rem_sh[assf_pkg::OPB_BITS-1:0];
      end
      default: begin
        acc_next = acc;
        b_next   = b_reg;
        rem_next = rem;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy  <= 1'b1;
        count <= (ctrl.op == assf_pkg::OP_MUL) ? assf_pkg::CNT_BITS'(assf_pkg::MUL_STEPS)
                                               : assf_pkg::CNT_BITS'(assf_pkg::DIV_STEPS);
      end else if (busy) begin
        count <= count - assf_pkg::CNT_BITS'(1);
        if (count == assf_pkg::CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      op    <= ctrl.op;
      a_reg <= operand_a;
      b_reg <= operand_b;
      rem   <= operand_a[assf_pkg::OPB_BITS-1:0];
      acc   <= '0;
    end else if (busy) begin
      acc   <= acc_next;
      b_reg <= b_next;
      rem   <= rem_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result    = acc;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |-> !busy)
    else $error("serial unit started while busy");

  a_count_live: assert property (@(posedge clk) disable iff (rst)
    busy |-> (count != '0))
    else $error("serial unit busy with empty step count");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("serial unit done held past one cycle");

endmodule
`default_nettype wire

[hdl/adaptive_snap_smoothing_filter.sv]
`default_nettype none
// Per sample: the error-average multiply and the sleep decision; unless the output
//   is held (asleep), the snap multiply, the weight divide unless the snap weight
//   saturates at one, and the smoothing multiply, each on the shared bit-serial unit
//   (17-step multiplies, 16-step divide). A new sample is taken only when idle.
// The result register frees the input side while a result beat waits.
// Synchronous active-high reset: registers to defaults, smooth/error/sleep state to zero.
// ----------------------------------------------------------------------------
// adaptive_snap_smoothing_filter: adaptive EMA filter with snap and sleep
// Edge snap on the sample, 0.4-weight error average, sleep hold, snap-curve
// weight min(1, 2x/(x+1)) and range clamp, all on one shared serial unit.
// ----------------------------------------------------------------------------
module adaptive_snap_smoothing_filter (
  input  logic                                    clk,
  input  logic                                    rst,
  // sample channel
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [assf_pkg::SAMPLE_BITS-1:0]        sample,
  // result channel
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [assf_pkg::SAMPLE_BITS-1:0]        filtered_value,
  output logic                                    value_changed,
  output logic                                    asleep,
  // register write channel
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [assf_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [assf_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  localparam int NV_BITS   = 16;                                    // snapped sample
  localparam int DIFF_BITS = assf_pkg::D_BITS + 1;
  localparam int STEP_BITS = assf_pkg::PROD_BITS - assf_pkg::FRAC_BITS;
  localparam int SUM_BITS  = STEP_BITS + 1;
  localparam logic signed [SUM_BITS-1:0] ERR_HI =
    (SUM_BITS'(1) << (assf_pkg::ERR_BITS - 1)) - SUM_BITS'(1);
  localparam logic signed [SUM_BITS-1:0] ERR_LO = ~ERR_HI;
  localparam logic [assf_pkg::SAMPLE_BITS-1:0] MAX_CODE = '1;

  // ---------------------------------------------------------------- registers
  logic                                   sleep_enable;
  logic                                   edge_snap_enable;
  logic [7:0]                             activity_threshold;
  logic [assf_pkg::MULT_BITS-1:0]         snap_multiplier;
  logic [12:0]                            full_scale;

  assf_pkg::state_t                       state;
  assf_pkg::state_t                       state_next;
  logic [assf_pkg::ACC_BITS-1:0]          smooth_acc;
  logic signed [assf_pkg::ERR_BITS-1:0]   error_average;
  logic                                   sleep_flag;
  logic [assf_pkg::SAMPLE_BITS-1:0]       last_output;

  logic signed [assf_pkg::D_BITS-1:0]     d_reg;     // snapped sample minus smooth, Q.16
  logic [assf_pkg::FRAC_BITS-1:0]         x_reg;     // scaled |d| when below one
  logic [assf_pkg::OPB_BITS-1:0]          w_reg;     // final snap weight, Q.16
  logic                                   held_reg;

  // serial unit hookup
  assf_pkg::unit_ctrl_t                   unit_ctrl;
  assf_pkg::unit_stat_t                   unit_stat;
  logic signed [assf_pkg::OPA_BITS-1:0]   unit_a;
  logic        [assf_pkg::OPB_BITS-1:0]   unit_b;
  logic signed [assf_pkg::PROD_BITS-1:0]  unit_result;

  // datapath nets
  logic signed [NV_BITS-1:0]              nv_raw;
  logic signed [NV_BITS-1:0]              thr_s;
  logic signed [NV_BITS-1:0]              fs_s;
  logic signed [NV_BITS-1:0]              nv_snap;
  logic signed [assf_pkg::D_BITS-1:0]     d_in;
  logic signed [DIFF_BITS-1:0]            ema_diff;
  logic signed [STEP_BITS-1:0]            prod_step;
  logic signed [SUM_BITS-1:0]             ea_sum;
  logic signed [assf_pkg::ERR_BITS-1:0]   ea_sat;
  logic [assf_pkg::ERR_BITS-1:0]          ea_abs;
  logic [assf_pkg::ERR_BITS-1:0]          thr_fx;
  logic                                   err_below;
  logic                                   held_now;
  logic [assf_pkg::D_BITS-1:0]            d_abs;
  logic [assf_pkg::MULT_BITS-1:0]         mult_clip;
  logic                                   x_big;
  logic [12:0]                            fs_minus_one;
  logic [assf_pkg::SAMPLE_BITS-1:0]       top_code;
  logic [assf_pkg::ACC_BITS-1:0]          top_fx;
  logic signed [SUM_BITS-1:0]             sm_sum;
  logic [assf_pkg::ACC_BITS-1:0]          sm_clamped;
  logic [assf_pkg::SAMPLE_BITS-1:0]       value;
  logic                                   out_load;

  // sleep turns the weight into (w + 1) / 2
  function automatic logic [assf_pkg::OPB_BITS-1:0] weight_adjust(
    input logic [assf_pkg::OPB_BITS-1:0] w,
    input logic                          halve
  );
    logic [assf_pkg::OPB_BITS:0] w_sum;
    w_sum = {1'b0, w} + {1'b0, assf_pkg::ONE_FX};
    return halve ? w_sum[assf_pkg::OPB_BITS:1] : w;
  endfunction

  // ---------------------------------------------------------------- config port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sleep_enable       <= 1'b1;
      edge_snap_enable   <= 1'b1;
      activity_threshold <= 8'd4;
      snap_multiplier    <= 16'd328;
      full_scale         <= 13'd1024;
    end else if (cfg_valid) begin
      unique case (assf_pkg::cfg_reg_t'(cfg_index))
        assf_pkg::CFG_SLEEP_ENABLE:       sleep_enable       <= cfg_data[0];
        assf_pkg::CFG_EDGE_SNAP_ENABLE:   edge_snap_enable   <= cfg_data[0];
        assf_pkg::CFG_ACTIVITY_THRESHOLD: activity_threshold <= cfg_data[7:0];
        assf_pkg::CFG_SNAP_MULTIPLIER:    snap_multiplier    <= cfg_data;
        assf_pkg::CFG_FULL_SCALE:         full_scale         <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  // Edge snap: samples within threshold of either end get stretched outward.
  // The stretched value may overshoot the range; only smooth_acc is clamped.
  always_comb begin
    nv_raw  = NV_BITS'(signed'({1'b0, sample}));
    thr_s   = NV_BITS'(signed'({1'b0, activity_threshold}));
    fs_s    = NV_BITS'(signed'({1'b0, full_scale}));
    nv_snap = nv_raw;
    if (sleep_enable && edge_snap_enable) begin
      if (nv_raw < thr_s) begin
        nv_snap = (nv_raw <<< 1) - thr_s;
      end else if (nv_raw > fs_s - thr_s) begin
        nv_snap = (nv_raw <<< 1) - fs_s + thr_s;
      end
    end
    d_in = (assf_pkg::D_BITS'(nv_snap) <<< assf_pkg::FRAC_BITS)
         - assf_pkg::D_BITS'(signed'({1'b0, smooth_acc}));
  end

  // Error average: ea += floor((d - ea) * 0.4), saturated to 31 bits.
  // The product's floor comes from the arithmetic shift.
  always_comb begin
    ema_diff  = DIFF_BITS'(d_reg) - DIFF_BITS'(error_average);
    prod_step = STEP_BITS'(unit_result >>> assf_pkg::FRAC_BITS);
    ea_sum    = SUM_BITS'(error_average) + SUM_BITS'(prod_step);
    if (ea_sum > ERR_HI) begin
      ea_sat = ERR_HI[assf_pkg::ERR_BITS-1:0];
    end else if (ea_sum < ERR_LO) begin
      ea_sat = ERR_LO[assf_pkg::ERR_BITS-1:0];
    end else begin
      ea_sat = ea_sum[assf_pkg::ERR_BITS-1:0];
    end
  end

  // Sleep decision: |ea| below threshold. -(-2^30) fits as unsigned 31 bits.
  always_comb begin
    ea_abs    = error_average[assf_pkg::ERR_BITS-1] ? assf_pkg::ERR_BITS'(-error_average)
                                                    : assf_pkg::ERR_BITS'(error_average);
    thr_fx    = assf_pkg::ERR_BITS'({activity_threshold, {assf_pkg::FRAC_BITS{1'b0}}});
    err_below = (ea_abs < thr_fx);
    held_now  = sleep_enable && err_below;
  end

  // Snap curve inputs: |d| times the multiplier, capped at 1.0.
  // x >= 1.0 exactly when the product reaches 2^(15+16).
  always_comb begin
    d_abs     = d_reg[assf_pkg::D_BITS-1] ? assf_pkg::D_BITS'(-d_reg)
                                          : assf_pkg::D_BITS'(d_reg);
    mult_clip = (snap_multiplier > assf_pkg::MULT_ONE) ? assf_pkg::MULT_ONE : snap_multiplier;
    x_big     = |unit_result[assf_pkg::PROD_BITS-1:assf_pkg::MULT_SHIFT + assf_pkg::FRAC_BITS];
  end

  // Smooth update and clamp to [0, top]. Full scale 0 or 1 pins top at 0;
  // top never goes past the largest sample code.
  always_comb begin
    fs_minus_one = (full_scale == '0) ? '0 : full_scale - 13'd1;
    top_code     = (fs_minus_one > 13'(MAX_CODE)) ? MAX_CODE
                                                  : fs_minus_one[assf_pkg::SAMPLE_BITS-1:0];
    top_fx       = {top_code, {assf_pkg::FRAC_BITS{1'b0}}};
    sm_sum       = SUM_BITS'(signed'({1'b0, smooth_acc})) + SUM_BITS'(prod_step);
    if (sm_sum[SUM_BITS-1]) begin
      sm_clamped = '0;
    end else if (sm_sum > SUM_BITS'(signed'({1'b0, top_fx}))) begin
      sm_clamped = top_fx;
    end else begin
      sm_clamped = sm_sum[assf_pkg::ACC_BITS-1:0];
    end
    value = smooth_acc[assf_pkg::ACC_BITS-1:assf_pkg::FRAC_BITS];
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      assf_pkg::S_IDLE:        if (in_valid) state_next = assf_pkg::S_EMA_GO;
      assf_pkg::S_EMA_GO:      state_next = assf_pkg::S_EMA_WAIT;
      assf_pkg::S_EMA_WAIT:    if (unit_stat.done) state_next = assf_pkg::S_SLEEP;
      assf_pkg::S_SLEEP:       state_next = held_now ? assf_pkg::S_FINISH
                                                     : assf_pkg::S_XMUL_GO;
      assf_pkg::S_XMUL_GO:     state_next = assf_pkg::S_XMUL_WAIT;
      assf_pkg::S_XMUL_WAIT: begin
        if (unit_stat.done) begin
          state_next = x_big ? assf_pkg::S_SMOOTH_GO : assf_pkg::S_DIV_GO;
        end
      end
      assf_pkg::S_DIV_GO:      state_next = assf_pkg::S_DIV_WAIT;
      assf_pkg::S_DIV_WAIT:    if (unit_stat.done) state_next = assf_pkg::S_SMOOTH_GO;
      assf_pkg::S_SMOOTH_GO:   state_next = assf_pkg::S_SMOOTH_WAIT;
      assf_pkg::S_SMOOTH_WAIT: if (unit_stat.done) state_next = assf_pkg::S_FINISH;
      assf_pkg::S_FINISH:      if (!out_valid || out_ready) state_next = assf_pkg::S_IDLE;
      default:                 state_next = assf_pkg::S_IDLE;
    endcase
  end

  // Unit operands per phase. Division starts with remainder 2x against
  // x + 1.0; the quotient bits are the weight 2x/(x+1) in Q.16.
  always_comb begin
    in_ready        = (state == assf_pkg::S_IDLE);
    out_load        = (state == assf_pkg::S_FINISH) && (!out_valid || out_ready);
    unit_ctrl.start = 1'b0;
    unit_ctrl.op    = assf_pkg::OP_MUL;
    unit_a          = '0;
    unit_b          = '0;
    unique case (state)
      assf_pkg::S_EMA_GO: begin
        unit_ctrl.start = 1'b1;
        unit_a          = assf_pkg::OPA_BITS'(ema_diff);
        unit_b          = assf_pkg::EMA_WEIGHT;
      end
      assf_pkg::S_XMUL_GO: begin
        unit_ctrl.start = 1'b1;
        unit_a          = assf_pkg::OPA_BITS'(d_abs);
        unit_b          = assf_pkg::OPB_BITS'(mult_clip);
      end
      assf_pkg::S_DIV_GO: begin
        unit_ctrl.start = 1'b1;
        unit_ctrl.op    = assf_pkg::OP_DIV;
        unit_a          = assf_pkg::OPA_BITS'({x_reg, 1'b0});
        unit_b          = {1'b1, x_reg};
      end
      assf_pkg::S_SMOOTH_GO: begin
        unit_ctrl.start = 1'b1;
        unit_a          = assf_pkg::OPA_BITS'(d_reg);
        unit_b          = w_reg;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= assf_pkg::S_IDLE;
      out_valid     <= 1'b0;
      smooth_acc    <= '0;
      error_average <= '0;
      sleep_flag    <= 1'b0;
      last_output   <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid   <= 1'b1;
        last_output <= value;
      end else if (out_ready) begin
        out_valid   <= 1'b0;
      end
      if (state == assf_pkg::S_EMA_WAIT && unit_stat.done) begin
        error_average <= ea_sat;
      end
      if (state == assf_pkg::S_SLEEP && sleep_enable) begin
        sleep_flag <= err_below;
      end
      if (state == assf_pkg::S_SMOOTH_WAIT && unit_stat.done) begin
        smooth_acc <= sm_clamped;
      end
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      d_reg <= d_in;
    end
    if (state == assf_pkg::S_SLEEP) begin
      held_reg <= held_now;
    end
    if (state == assf_pkg::S_XMUL_WAIT && unit_stat.done) begin
      x_reg <= unit_result[assf_pkg::MULT_SHIFT +: assf_pkg::FRAC_BITS];
      w_reg <= weight_adjust(assf_pkg::ONE_FX, sleep_enable);
    end
    if (state == assf_pkg::S_DIV_WAIT && unit_stat.done) begin
      w_reg <= weight_adjust(assf_pkg::OPB_BITS'(unit_result[assf_pkg::FRAC_BITS-1:0]),
                             sleep_enable);
    end
    if (out_load) begin
      filtered_value <= value;
      value_changed  <= (value != last_output);
      asleep         <= held_reg;
    end
  end

  assf_serial_unit u_serial (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (unit_ctrl),
    .operand_a (unit_a),
    .operand_b (unit_b),
    .stat      (unit_stat),
    .result    (unit_result)
  );

  // ---------------------------------------------------------------- checks
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    unit_stat.done |-> (state == assf_pkg::S_EMA_WAIT || state == assf_pkg::S_XMUL_WAIT ||
                        state == assf_pkg::S_DIV_WAIT || state == assf_pkg::S_SMOOTH_WAIT))
    else $error("serial unit finished outside a wait phase");

  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    state == assf_pkg::S_SMOOTH_GO |-> w_reg <= assf_pkg::ONE_FX)
    else $error("snap weight above one");

  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    (state == assf_pkg::S_FINISH && (!out_valid || out_ready))
      |=> (out_valid && state == assf_pkg::S_IDLE))
    else $error("finished result not loaded into output register");

endmodule
`default_nettype wire

[tb/sv/snap_filter_monitor.sv]
// ----------------------------------------------------------------------------
// snap_filter_monitor: result predictor and comparator for the snap filter
// Tracks register writes and sample beats, predicts each result beat and
// compares it field by field against what the filter sends back.
// ----------------------------------------------------------------------------
module snap_filter_monitor (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [assf_pkg::SAMPLE_BITS-1:0]    sample,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [assf_pkg::SAMPLE_BITS-1:0]    filtered_value,
  input  logic                                value_changed,
  input  logic                                asleep,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [assf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [assf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                  mismatches,
  output int                                  outstanding,
  output int                                  held_seen
);

  localparam longint ONE_Q    = 64'sd1 << assf_pkg::FRAC_BITS;
  localparam longint EMA_W    = (2 * ONE_Q + 2) / 5;
  localparam longint MULT_CAP = 64'sd1 << assf_pkg::MULT_SHIFT;
  localparam longint MAX_CODE = (64'sd1 << assf_pkg::SAMPLE_BITS) - 1;
  localparam longint ERR_HI   = (64'sd1 << (assf_pkg::ERR_BITS - 1)) - 1;
  localparam longint ERR_LO   = -(64'sd1 << (assf_pkg::ERR_BITS - 1));

  typedef struct packed {
    logic [assf_pkg::SAMPLE_BITS-1:0] value;
    logic                             changed;
    logic                             held;
  } reading_t;

  // register copies
  logic                             sleep_en;
  logic                             edge_en;
  logic [7:0]                       thresh;
  logic [assf_pkg::MULT_BITS-1:0]   snap_mult;
  logic [12:0]                      full_scale;

  // filter state, Q.16
  longint                           smooth_q;
  longint                           err_q;
  logic                             sleep_st;
  logic [assf_pkg::SAMPLE_BITS-1:0] prev_value;

  reading_t expected_readings[$];
  reading_t want;

  // One sample through the filter; updates the state copy.
  function automatic reading_t smooth_step(input logic [assf_pkg::SAMPLE_BITS-1:0] raw);
    longint   thr, fs, nv, d, ad, x, w, mult, top, ae;
    logic     held;
    reading_t r;
    thr = thresh;
    fs  = full_scale;
    nv  = raw;
    if (sleep_en && edge_en) begin
      // stretch near the range ends; may overshoot
      if (nv < thr)
        nv = nv * 2 - thr;
      else if (nv > fs - thr)
        nv = nv * 2 - fs + thr;
    end
    d = nv * ONE_Q - smooth_q;
    err_q = err_q + (((d - err_q) * EMA_W) >>> assf_pkg::FRAC_BITS);
    if (err_q > ERR_HI) err_q = ERR_HI;
    if (err_q < ERR_LO) err_q = ERR_LO;
    if (sleep_en) begin
      ae = (err_q < 0) ? -err_q : err_q;
      sleep_st = (ae < thr * ONE_Q);
    end
    held = sleep_en && sleep_st;
    if (!held) begin
      ad   = (d < 0) ? -d : d;
      mult = snap_mult;
      if (mult > MULT_CAP) mult = MULT_CAP;
      x = (ad * mult) >>> assf_pkg::MULT_SHIFT;
      w = (x >= ONE_Q) ? ONE_Q : (2 * x * ONE_Q) / (x + ONE_Q);
      if (sleep_en) w = (w + ONE_Q) >>> 1;
      smooth_q = smooth_q + ((d * w) >>> assf_pkg::FRAC_BITS);
      top = (fs >= 1) ? fs - 1 : 0;
      if (top > MAX_CODE) top = MAX_CODE;
      if (smooth_q < 0)
        smooth_q = 0;
      else if (smooth_q > top * ONE_Q)
        smooth_q = top * ONE_Q;
    end
    r.value    = smooth_q[assf_pkg::FRAC_BITS +: assf_pkg::SAMPLE_BITS];
    r.changed  = (r.value != prev_value);
    r.held     = held;
    prev_value = r.value;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      sleep_en   = 1'b1;
      edge_en    = 1'b1;
      thresh     = 8'd4;
      snap_mult  = 16'd328;
      full_scale = 13'd1024;
      smooth_q   = 0;
      err_q      = 0;
      sleep_st   = 1'b0;
      prev_value = '0;
      expected_readings.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          assf_pkg::CFG_SLEEP_ENABLE:       sleep_en   = cfg_data[0];
          assf_pkg::CFG_EDGE_SNAP_ENABLE:   edge_en    = cfg_data[0];
          assf_pkg::CFG_ACTIVITY_THRESHOLD: thresh     = cfg_data[7:0];
          assf_pkg::CFG_SNAP_MULTIPLIER:    snap_mult  = cfg_data[assf_pkg::MULT_BITS-1:0];
          assf_pkg::CFG_FULL_SCALE:         full_scale = cfg_data[12:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (asleep) held_seen++;
        if (expected_readings.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat, expected none, got value %0d", $time,
                   filtered_value);
        end else begin
          want = expected_readings.pop_front();
          if (want.value !== filtered_value || want.changed !== value_changed ||
              want.held !== asleep) begin
            mismatches++;
            if (want.value !== filtered_value)
              $display("%0t: filtered_value expected %0d, got %0d", $time, want.value,
                       filtered_value);
            if (want.changed !== value_changed)
              $display("%0t: value_changed expected %0b, got %0b", $time, want.changed,
                       value_changed);
            if (want.held !== asleep)
              $display("%0t: asleep expected %0b, got %0b", $time, want.held, asleep);
          end
        end
      end
      if (in_valid && in_ready)
        expected_readings.push_back(smooth_step(sample));
    end
    outstanding = expected_readings.size();
  end

endmodule

[tb/sv/adaptive_snap_smoothing_filter_tb.sv]
// ----------------------------------------------------------------------------
// adaptive_snap_smoothing_filter_tb: regression bench for the snap filter
// Directed corner samples, then random sample bursts (steady levels with
// noise, ramps, jumps, edge hugging) under changing register settings and
// three back-pressure mixes. A side monitor predicts and checks every result.
// ----------------------------------------------------------------------------
module adaptive_snap_smoothing_filter_tb;

  localparam int QUIET_LIMIT = 4000;  // cycles with no beat on any channel
  localparam int SEG_ITEMS   = 115;   // samples per register setting
  localparam int SEGS        = 4;     // settings per idle mix
  localparam int DRAIN_WAIT  = 100;   // extra wait after the last result comes back

  logic                               clk       = 1'b0;
  logic                               rst       = 1'b1;
  logic                               in_valid  = 1'b0;
  logic [assf_pkg::SAMPLE_BITS-1:0]   sample    = '0;
  logic                               out_ready = 1'b0;
  logic                               cfg_valid = 1'b0;
  logic [assf_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [assf_pkg::CFG_DATA_BITS-1:0] cfg_data  = '0;
  logic                               in_ready;
  logic                               out_valid;
  logic [assf_pkg::SAMPLE_BITS-1:0]   filtered_value;
  logic                               value_changed;
  logic                               asleep;
  logic                               cfg_ready;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles  = 0;
  int samples_sent  = 0;
  int cfg_writes    = 0;
  int mismatches;
  int outstanding;
  int held_seen;

  adaptive_snap_smoothing_filter i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample         (sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .filtered_value (filtered_value),
    .value_changed  (value_changed),
    .asleep         (asleep),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  snap_filter_monitor i_mon (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample         (sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .filtered_value (filtered_value),
    .value_changed  (value_changed),
    .asleep         (asleep),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .held_seen      (held_seen)
  );

  always #5 clk = ~clk;

  // Result side back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: if no channel completes a beat within QUIET_LIMIT, the run ends.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One sample beat. Entered and left at a falling edge; valid stays high on
  // return so that back-to-back beats never drop it in between.
  task automatic send_sample(input logic [assf_pkg::SAMPLE_BITS-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    samples_sent++;
  endtask

  // Sender pauses until every predicted result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // One register beat; valid is left high for the caller to drop.
  task automatic put_reg(input assf_pkg::cfg_reg_t idx,
                         input logic [assf_pkg::CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_writes++;
  endtask

  // Full register load, only with the filter idle.
  task automatic program_filter(input logic [assf_pkg::CFG_DATA_BITS-1:0] sl, ed, thr, mult,
                                fs);
    wait_drained();
    put_reg(assf_pkg::CFG_SLEEP_ENABLE, sl);
    put_reg(assf_pkg::CFG_EDGE_SNAP_ENABLE, ed);
    put_reg(assf_pkg::CFG_ACTIVITY_THRESHOLD, thr);
    put_reg(assf_pkg::CFG_SNAP_MULTIPLIER, mult);
    put_reg(assf_pkg::CFG_FULL_SCALE, fs);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    // reset settings: range ends, edge overshoot on both sides, a steady run
    // that should put the filter to sleep, then a wake-up jump
    int dir_a [11] = '{0, 4095, 4095, 2, 1023, 1020, 1021, 1021, 1021, 1021, 512};
    // sleep off, multiplier above one, full scale of one
    int dir_b [3]  = '{4095, 0, 2048};
    // full scale of zero, widest threshold, zero multiplier
    int dir_c [3]  = '{0, 300, 4095};
    // full scale above the code range, zero threshold, multiplier of one
    int dir_d [4]  = '{4095, 0, 4095, 1};
    int mode, burst_left, level, step, noise, s, seg_fs, seg_top, pick;
    logic [7:0]  thr_v;
    logic [15:0] mult_v;
    logic [12:0] fs_v;

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // ---- directed corners, no idling ----
    foreach (dir_a[i]) send_sample(assf_pkg::SAMPLE_BITS'(dir_a[i]));
    program_filter(16'h0000, 16'h0001, 16'd4, 16'hFFFF, 16'd1);
    foreach (dir_b[i]) send_sample(assf_pkg::SAMPLE_BITS'(dir_b[i]));
    program_filter(16'h0001, 16'h0001, 16'd255, 16'd0, 16'd0);
    foreach (dir_c[i]) send_sample(assf_pkg::SAMPLE_BITS'(dir_c[i]));
    program_filter(16'h0001, 16'h0000, 16'd0, 16'd32768, 16'd8191);
    foreach (dir_d[i]) send_sample(assf_pkg::SAMPLE_BITS'(dir_d[i]));

    // ---- random bursts under three back-pressure mixes ----
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 81;
        end
        1: begin
          send_idle_pct = 81;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < SEGS; seg++) begin
        // mostly small thresholds so that sleeping and waking both happen
        pick = $urandom_range(5);
        thr_v = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(12, 1));
        pick = $urandom_range(5);
        case (pick)
          0:       mult_v = 16'd0;
          1:       mult_v = 16'd32768;
          2:       mult_v = 16'($urandom);
          default: mult_v = 16'($urandom_range(4000, 100));
        endcase
        pick = $urandom_range(9);
        case (pick)
          0:       fs_v = 13'($urandom_range(1));
          1:       fs_v = 13'd4096;
          2:       fs_v = 13'd8191;
          3:       fs_v = 13'($urandom);
          default: fs_v = 13'($urandom_range(4096, 2));
        endcase
        // junk in the unused upper data bits must be ignored
        program_filter(16'($urandom), 16'($urandom), {8'($urandom), thr_v}, mult_v,
                       {3'($urandom), fs_v});
        seg_fs  = fs_v;
        seg_top = (seg_fs < 1) ? 0 : seg_fs - 1;
        if (seg_top > 4095) seg_top = 4095;
        burst_left = 0;
        repeat (SEG_ITEMS) begin
          if (burst_left == 0) begin
            mode       = $urandom_range(9);
            burst_left = $urandom_range(40, 4);
            level      = $urandom_range(seg_top);
            noise      = $urandom_range(6);
            step       = int'($urandom_range(16)) - 8;
          end
          burst_left--;
          if (mode <= 5) begin
            // steady level with jitter, slow drift now and then
            if ($urandom_range(15) == 0) level += int'($urandom_range(4)) - 2;
            s = level + int'($urandom_range(2 * noise)) - noise;
          end else if (mode <= 7) begin
            level += step;
            if (level < 0) level = 0;
            if (level > 4095) level = 4095;
            s = level;
          end else if (mode == 8) begin
            s = $urandom_range(4095);
          end else begin
            // hug one end of the range
            s = ($urandom_range(1) == 0) ? int'($urandom_range(15))
                                          : seg_top - int'($urandom_range(15));
          end
          if (s < 0) s = 0;
          if (s > 4095) s = 4095;
          send_sample(assf_pkg::SAMPLE_BITS'(s));
        end
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("Ran %0d samples through %0d register writes over three back-pressure mixes;",
             samples_sent, cfg_writes);
    $display("%0d results came back with the output held.", held_seen);
    if (mismatches == 0 && outstanding == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
